>>> src/heater_fault_monitor_core_defines.svh
// ----------------------------------------------------------------------------
// Heater fault monitor assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef HEATER_FAULT_MONITOR_CORE_DEFINES_SVH
`define HEATER_FAULT_MONITOR_CORE_DEFINES_SVH

// checked outside reset only
`define HFM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/hfm_pkg.sv
// ----------------------------------------------------------------------------
// Heater fault monitor package
// Item layouts, configuration set, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfm_pkg;

  localparam int SAMPLE_W   = 129;
  localparam int IN_DATA_W  = 136;
  localparam int FLAGS_W    = 6;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_PROBE_RAW_MIN      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROBE_RAW_MAX      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_JUNCTION_MV_MIN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_JUNCTION_MV_MAX    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PROBE_OT_LIMIT     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_JUNCTION_OT_LIMIT  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RISE_TIMEOUT_MS    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_RISE_MIN_DELTA     = 3'd7;

  localparam logic [15:0]        RST_PROBE_RAW_MIN     = 16'd0;
  localparam logic [15:0]        RST_PROBE_RAW_MAX     = 16'd4094;
  localparam logic [15:0]        RST_JUNCTION_MV_MIN   = 16'd100;
  localparam logic [15:0]        RST_JUNCTION_MV_MAX   = 16'd3200;
  localparam logic signed [15:0] RST_PROBE_OT_LIMIT    = 16'sd3000;
  localparam logic signed [15:0] RST_JUNCTION_OT_LIMIT = 16'sd1000;
  localparam logic [31:0]        RST_RISE_TIMEOUT_MS   = 32'd90000;
  localparam logic [14:0]        RST_RISE_MIN_DELTA    = 15'd30;

  // first listed member sits in the highest bits
  typedef struct packed {
    logic [31:0]        time_ms;
    logic               heater_on;
    logic [15:0]        junction_mv;
    logic [15:0]        right_raw_code;
    logic [15:0]        left_raw_code;
    logic signed [15:0] junction_temp;
    logic signed [15:0] right_temp;
    logic signed [15:0] left_temp;
  } sample_t;

  typedef struct packed {
    logic critical_fault;
    logic no_rise_fault;
    logic overtemp_fault;
    logic junction_sensor_fault;
    logic right_sensor_fault;
    logic left_sensor_fault;
  } flags_t;

  typedef struct packed {
    logic [15:0]        probe_raw_min;
    logic [15:0]        probe_raw_max;
    logic [15:0]        junction_mv_min;
    logic [15:0]        junction_mv_max;
    logic signed [15:0] probe_overtemp_limit;
    logic signed [15:0] junction_overtemp_limit;
    logic [31:0]        rise_timeout_ms;
    logic [14:0]        rise_min_delta;
  } cfg_t;

  typedef struct packed {
    logic tracking_active;
    logic no_rise_latched;
  } wd_status_t;

  typedef struct packed {
    logic left_sensor_fault;
    logic right_sensor_fault;
    logic junction_sensor_fault;
    logic overtemp_fault;
  } limit_flags_t;

endpackage

>>> src/hfm_limit_check.sv
// ----------------------------------------------------------------------------
// Heater fault monitor limit check
// Range checks on raw codes and millivolts, over-temperature compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfm_limit_check (
  input  hfm_pkg::sample_t      sample,
  input  hfm_pkg::cfg_t         cfg,
  output hfm_pkg::limit_flags_t flags
);
  import hfm_pkg::*;

  always_comb begin
    flags.left_sensor_fault  = (sample.left_raw_code < cfg.probe_raw_min) ||
                               (sample.left_raw_code > cfg.probe_raw_max);
    flags.right_sensor_fault = (sample.right_raw_code < cfg.probe_raw_min) ||
                               (sample.right_raw_code > cfg.probe_raw_max);
    flags.junction_sensor_fault = (sample.junction_mv < cfg.junction_mv_min) ||
                                  (sample.junction_mv > cfg.junction_mv_max);
    flags.overtemp_fault = (sample.left_temp > cfg.probe_overtemp_limit) ||
                           (sample.right_temp > cfg.probe_overtemp_limit) ||
                           (sample.junction_temp > cfg.junction_overtemp_limit);
  end

endmodule

>>> src/hfm_watchdog.sv
// ----------------------------------------------------------------------------
// Heater fault monitor rise watchdog
// Tracks the hotter probe while heating and latches a missing rise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfm_watchdog (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  hfm_pkg::sample_t    sample,
  input  hfm_pkg::cfg_t       cfg,
  output logic                no_rise_fault,
  output hfm_pkg::wd_status_t status
);
  import hfm_pkg::*;

  logic               tracking_active;
  logic               tracking_active_next;
  logic               no_rise_latched;
  logic               no_rise_latched_next;
  logic [31:0]        window_start_time;
  logic [31:0]        window_start_time_next;
  logic signed [15:0] window_start_temp;
  logic signed [15:0] window_start_temp_next;

  logic signed [15:0] hot;
  logic [31:0]        elapsed;
  logic signed [16:0] rise;

  always_comb begin
    hot     = (sample.right_temp > sample.left_temp) ? sample.right_temp : sample.left_temp;
    elapsed = sample.time_ms - window_start_time;
    rise    = 17'(hot) - 17'(window_start_temp);

    tracking_active_next   = tracking_active;
    no_rise_latched_next   = no_rise_latched;
    window_start_time_next = window_start_time;
    window_start_temp_next = window_start_temp;

    if (sample.heater_on && !no_rise_latched) begin
      if (!tracking_active) begin
        tracking_active_next   = 1'b1;
        window_start_time_next = sample.time_ms;
        window_start_temp_next = hot;
      end else if (elapsed >= cfg.rise_timeout_ms) begin
        if (rise < $signed({2'b00, cfg.rise_min_delta})) begin
          no_rise_latched_next = 1'b1;
        end else begin
          window_start_time_next = sample.time_ms;
          window_start_temp_next = hot;
        end
      end
    end else if (!sample.heater_on) begin
      tracking_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_active   <= 1'b0;
      no_rise_latched   <= 1'b0;
      window_start_time <= '0;
      window_start_temp <= '0;
    end else if (step) begin
      tracking_active   <= tracking_active_next;
      no_rise_latched   <= no_rise_latched_next;
      window_start_time <= window_start_time_next;
      window_start_temp <= window_start_temp_next;
    end
  end

  assign no_rise_fault          = no_rise_latched_next;
  assign status.tracking_active = tracking_active;
  assign status.no_rise_latched = no_rise_latched;

endmodule

>>> src/hfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Heater fault monitor configuration registers
// Write-only register file decoded from the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [hfm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [hfm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hfm_pkg::cfg_t                      cfg
);
  import hfm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_raw_min           <= RST_PROBE_RAW_MIN;
      cfg.probe_raw_max           <= RST_PROBE_RAW_MAX;
      cfg.junction_mv_min         <= RST_JUNCTION_MV_MIN;
      cfg.junction_mv_max         <= RST_JUNCTION_MV_MAX;
      cfg.probe_overtemp_limit    <= RST_PROBE_OT_LIMIT;
      cfg.junction_overtemp_limit <= RST_JUNCTION_OT_LIMIT;
      cfg.rise_timeout_ms         <= RST_RISE_TIMEOUT_MS;
      cfg.rise_min_delta          <= RST_RISE_MIN_DELTA;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_PROBE_RAW_MIN:     cfg.probe_raw_min           <= cfg_data[15:0];
        REG_PROBE_RAW_MAX:     cfg.probe_raw_max           <= cfg_data[15:0];
        REG_JUNCTION_MV_MIN:   cfg.junction_mv_min         <= cfg_data[15:0];
        REG_JUNCTION_MV_MAX:   cfg.junction_mv_max         <= cfg_data[15:0];
        REG_PROBE_OT_LIMIT:    cfg.probe_overtemp_limit    <= $signed(cfg_data[15:0]);
        REG_JUNCTION_OT_LIMIT: cfg.junction_overtemp_limit <= $signed(cfg_data[15:0]);
        REG_RISE_TIMEOUT_MS:   cfg.rise_timeout_ms         <= cfg_data;
        REG_RISE_MIN_DELTA:    cfg.rise_min_delta          <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/heater_fault_monitor_core.sv
// ----------------------------------------------------------------------------
// Heater fault monitor core
// Checks each oven sample and returns one item of fault flags.
// ----------------------------------------------------------------------------
// One result item per input item, one item per cycle sustained while m_tready
// is high. A sample register, then the range/limit compares and the rise
// watchdog (a 32-bit time and a 17-bit rise subtract and compare) feed the
// result register; it advances when empty or taken, and the sample register
// also loads when empty. The no-rise flag is sticky until reset.
`timescale 1ns / 1ps

`include "heater_fault_monitor_core_defines.svh"

module heater_fault_monitor_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [hfm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hfm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // left_temp, right_temp, junction_temp, left_raw_code, right_raw_code,
  // junction_mv, heater_on, time_ms, zero pad
  input  logic [hfm_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // left_sensor_fault, right_sensor_fault, junction_sensor_fault,
  // overtemp_fault, no_rise_fault, critical_fault, zero pad
  output logic [hfm_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import hfm_pkg::*;

  cfg_t         cfg;
  sample_t      sample;
  logic         in_valid;
  logic         advance;
  logic         step;
  limit_flags_t lim;
  logic         no_rise_fault;
  wd_status_t   wd_status;
  flags_t       flags_next;
  flags_t       flags;

  assign advance  = !m_tvalid || m_tready;
  assign step     = advance && in_valid;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      sample <= s_tdata[SAMPLE_W-1:0];
    end
  end

  hfm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hfm_limit_check u_limit (
    .sample (sample),
    .cfg    (cfg),
    .flags  (lim)
  );

  hfm_watchdog u_wd (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .sample        (sample),
    .cfg           (cfg),
    .no_rise_fault (no_rise_fault),
    .status        (wd_status)
  );

  always_comb begin
    flags_next.left_sensor_fault     = lim.left_sensor_fault;
    flags_next.right_sensor_fault    = lim.right_sensor_fault;
    flags_next.junction_sensor_fault = lim.junction_sensor_fault;
    flags_next.overtemp_fault        = lim.overtemp_fault;
    flags_next.no_rise_fault         = no_rise_fault;
    flags_next.critical_fault        = lim.left_sensor_fault || lim.right_sensor_fault ||
                                       lim.junction_sensor_fault || lim.overtemp_fault ||
                                       no_rise_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      flags <= flags_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - FLAGS_W){1'b0}}, flags};

  `HFM_ASSERT_ALWAYS(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
  `HFM_ASSERT_RST(a_latch_sticky, !$past(rst) && $past(wd_status.no_rise_latched) |-> wd_status.no_rise_latched, "no-rise latch cleared")
  `HFM_ASSERT_RST(a_latch_needs_tracking, !$past(rst) && $rose(wd_status.no_rise_latched) |-> $past(wd_status.tracking_active), "no-rise latched without tracking")
  `HFM_ASSERT_RST(a_latch_on_step, !$past(rst) && $rose(wd_status.no_rise_latched) |-> $past(step), "no-rise latched without an item")

endmodule
